### design/ogg_page_framer_assert.svh
// Assertion macros shared by the framer modules.
`ifndef OGG_PAGE_FRAMER_ASSERT_SVH
`define OGG_PAGE_FRAMER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequence holds in the next cycle.
`define OPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### design/opf_pkg.sv
`default_nettype none
package opf_pkg;
   localparam int unsigned HdrBytes = 27;
   localparam logic [31:0] CrcPoly = 32'h04c1_1db7;
   localparam logic [31:0] SerialReset = 32'h4d49_4331;
   localparam logic [15:0] StepReset = 16'd320;
   localparam logic [7:0] FlagBegin = 8'h02;
   localparam logic [7:0] FlagEnd = 8'h04;
   localparam logic [7:0] LaceFull = 8'd255;
   localparam logic ActPush = 1'b0;
   localparam logic ActPull = 1'b1;
   localparam logic [0:0] RegSerial = 1'b0;
   localparam logic [0:0] RegStep = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       packet_end;
      logic       begin_stream;
      logic       end_stream;
      logic       header_packet;
   } req_type;

   typedef struct packed {
      logic [7:0] page_byte;
      logic       byte_valid;
      logic       page_last;
      logic       truncated;
   } rsp_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic push;         // store the request byte
      logic close;        // latch header fields
      logic crc_start;    // clear position and CRC
      logic crc_step;     // fold the fetched byte into the CRC
      logic crc_done;     // store CRC, rewind read position
      logic fetch;        // issue store read at the read position
      logic emit;         // present the fetched byte as a response
      logic emit_empty;   // present an all-zero response
   } opf_cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic at_last;      // read position is the final page byte
   } opf_stat_type;

   // One byte of CRC-32, unreflected, MSB first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

### design/opf_ram.sv
`default_nettype none
module opf_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/opf_datapath.sv
`default_nettype none
`include "ogg_page_framer_assert.svh"
module opf_datapath import opf_pkg::*; #(
   parameter int MaxPacket = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire opf_cmd_type  cmd,
   output opf_stat_type      stat,
   input  wire req_type      req,
   input  wire logic [31:0]  serial,
   input  wire logic [15:0]  step,
   output rsp_type           rsp_data,
   output logic              rsp_strobe
);
   localparam int AddrW = (MaxPacket > 1) ? $clog2(MaxPacket) : 1;
   localparam int LenW = $clog2(MaxPacket + 1);
   localparam int PosW = $clog2(MaxPacket + MaxPacket / 255 + 1 + HdrBytes + 1);
   localparam logic [LenW-1:0] MaxLen = LenW'(MaxPacket);

   logic [LenW-1:0] len_ff, len_in;
   logic [31:0] seq_ff, pseq_ff, pser_ff, crc_ff, chk_ff;
   logic [31:0] crc_next;
   logic [63:0] gran_ff, pgran_ff;
   logic [7:0] flags_ff;
   logic trunc_ff, trunc_in;
   logic [PosW-1:0] pos_ff;
   logic [PosW-1:0] fpos_ff;
   logic [7:0] nseg_ff, lastlace_ff;
   logic [PosW-1:0] total_ff;
   // Running length divided by 255, kept incrementally.
   logic [7:0] q_ff, r_ff, q_in, r_in;
   logic [7:0] ram_rd;
   logic [AddrW-1:0] rd_addr;
   logic [7:0] hbyte;
   logic in_payload_ff;
   logic [PosW-1:0] pay_off;
   logic [7:0] hbyte_ff, byte_sel_q;

   // Length, lacing quotient and remainder, and the truncation flag.
   always_comb begin
      len_in = len_ff;
      q_in = q_ff;
      r_in = r_ff;
      trunc_in = trunc_ff;
      if (cmd.push) begin
         if (len_ff < MaxLen) begin
            len_in = len_ff + 1'b1;
            if (r_ff == 8'd254) begin
               r_in = '0;
               q_in = q_ff + 1'b1;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end else begin
            trunc_in = 1'b1;
         end
      end
      if (cmd.emit && stat.at_last) begin
         len_in = '0;
         q_in = '0;
         r_in = '0;
         trunc_in = 1'b0;
      end
   end

   opf_ram #(.Width(8), .Depth(1 << AddrW)) u_store (
      .clock  (clock),
      .wr_en  (cmd.push && len_ff < MaxLen),
      .wr_addr(len_ff[AddrW-1:0]),
      .wr_data(req.data_byte),
      .rd_addr(rd_addr),
      .rd_data(ram_rd)
   );

   assign pay_off = pos_ff - PosW'(HdrBytes) - PosW'(nseg_ff);
   assign rd_addr = pay_off[AddrW-1:0];

   // Header and lacing bytes at the current read position.
   always_comb begin
      logic [PosW-1:0] p;
      logic [2:0] g;
      logic [1:0] k;
      p = pos_ff;
      g = p[2:0] - 3'd6;
      k = p[1:0] - 2'd2;
      hbyte = 8'd0;
      if (p < PosW'(4)) begin
         unique case (p[1:0])
            2'd0: hbyte = 8'h4f;
            2'd1: hbyte = 8'h67;
            2'd2: hbyte = 8'h67;
            default: hbyte = 8'h53;
         endcase
      end else if (p == PosW'(4)) begin
         hbyte = 8'd0;
      end else if (p == PosW'(5)) begin
         hbyte = flags_ff;
      end else if (p < PosW'(14)) begin
         hbyte = pgran_ff[8*g +: 8];
      end else if (p < PosW'(18)) begin
         hbyte = pser_ff[8*k +: 8];
      end else if (p < PosW'(22)) begin
         hbyte = pseq_ff[8*k +: 8];
      end else if (p < PosW'(26)) begin
         hbyte = chk_ff[8*k +: 8];
      end else if (p == PosW'(26)) begin
         hbyte = nseg_ff;
      end else begin
         hbyte = (p + 1'b1 < PosW'(HdrBytes) + PosW'(nseg_ff)) ? LaceFull : lastlace_ff;
      end
   end

   assign stat.at_last = (fpos_ff + 1'b1 >= total_ff);
   assign crc_next = crc_byte(crc_ff, byte_sel_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         seq_ff <= '0;
         gran_ff <= '0;
         flags_ff <= '0;
         chk_ff <= '0;
         pos_ff <= '0;
         trunc_ff <= 1'b0;
         q_ff <= '0;
         r_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit || cmd.emit_empty;
         len_ff <= len_in;
         q_ff <= q_in;
         r_ff <= r_in;
         trunc_ff <= trunc_in;
         if (cmd.close) begin
            flags_ff <= (req.begin_stream ? FlagBegin : 8'd0) |
                        (req.end_stream ? FlagEnd : 8'd0);
            if (!req.header_packet) begin
               gran_ff <= gran_ff + 64'(step);
            end
            seq_ff <= seq_ff + 1'b1;
         end
         if (cmd.crc_start || cmd.crc_done) begin
            pos_ff <= '0;
         end else if (cmd.fetch) begin
            pos_ff <= pos_ff + 1'b1;
         end
         // The checksum field reads as zero while the CRC pass runs.
         if (cmd.close) begin
            chk_ff <= '0;
         end else if (cmd.crc_done) begin
            chk_ff <= crc_next;
         end
      end
   end

   // Payload-side registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.close) begin
         pgran_ff <= req.header_packet ? 64'd0 : gran_ff + 64'(step);
         pseq_ff <= seq_ff;
         pser_ff <= serial;
      end
      if (cmd.crc_start) begin
         nseg_ff <= q_in + 1'b1;
         lastlace_ff <= r_in;
         total_ff <= PosW'(HdrBytes) + PosW'(q_in) + 1'b1 + PosW'(len_in);
         crc_ff <= '0;
      end
      if (cmd.fetch) begin
         fpos_ff <= pos_ff;
         in_payload_ff <= pos_ff >= PosW'(HdrBytes) + PosW'(nseg_ff);
      end
      if (cmd.crc_step) begin
         crc_ff <= crc_next;
      end
      if (cmd.emit || cmd.emit_empty) begin
         rsp_data.page_byte <= cmd.emit ? byte_sel_q : 8'd0;
         rsp_data.byte_valid <= cmd.emit;
         rsp_data.page_last <= cmd.emit && stat.at_last;
         rsp_data.truncated <= cmd.emit && trunc_ff;
      end
   end

   // Header bytes are registered alongside the store's read data.
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         hbyte_ff <= hbyte;
      end
   end
   assign byte_sel_q = in_payload_ff ? ram_rd : hbyte_ff;

   `OPF_ASSERT_IMP(a_len_cap, clock, reset, 1'b1, len_ff <= MaxLen, "length beyond capacity")
   `OPF_ASSERT_IMP(a_lace, clock, reset, 1'b1, r_ff < 8'd255, "lace remainder out of range")
   `OPF_ASSERT_NEXT(a_strobe, clock, reset, cmd.emit_empty, rsp_data.byte_valid == 1'b0,
      "empty response marked valid")
endmodule
`default_nettype wire

### design/opf_ctrl.sv
`default_nettype none
`include "ogg_page_framer_assert.svh"
module opf_ctrl import opf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire req_type       req,
   input  wire opf_stat_type  stat,
   output opf_cmd_type        cmd,
   output logic               busy
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_CRC_FETCH, ST_CRC_FOLD, ST_READY, ST_PULL_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic go;

   assign go = start && !busy;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (go && req.action == ActPush) begin
               cmd.push = 1'b1;
               if (req.packet_end) begin
                  cmd.close = 1'b1;
                  cmd.crc_start = 1'b1;
                  state_in = ST_CRC_FETCH;
               end
            end else if (go) begin
               cmd.emit_empty = 1'b1;
            end
         end
         ST_CRC_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = ST_CRC_FOLD;
         end
         ST_CRC_FOLD: begin
            cmd.crc_step = 1'b1;
            if (stat.at_last) begin
               cmd.crc_done = 1'b1;
               state_in = ST_READY;
            end else begin
               state_in = ST_CRC_FETCH;
            end
         end
         ST_READY: begin
            if (go && req.action == ActPull) begin
               cmd.fetch = 1'b1;
               state_in = ST_PULL_WAIT;
            end
         end
         ST_PULL_WAIT: begin
            cmd.emit = 1'b1;
            state_in = stat.at_last ? ST_IDLE : ST_READY;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy <= (state_in == ST_CRC_FETCH) || (state_in == ST_CRC_FOLD) ||
                 (state_in == ST_PULL_WAIT);
      end
   end

   `OPF_ASSERT_IMP(a_busy, clock, reset, state_ff == ST_CRC_FOLD, busy, "idle during CRC")
   `OPF_ASSERT_NEXT(a_crc, clock, reset, cmd.close, state_ff == ST_CRC_FETCH,
      "close did not start CRC")
   `OPF_ASSERT_IMP(a_excl, clock, reset, 1'b1, !(cmd.push && cmd.emit), "push with emit")
endmodule
`default_nettype wire

### design/ogg_page_framer.sv
`default_nettype none
// Channel   Ports                    Handshake
// request   start, busy, req_data    taken when start is high and busy low
// response  rsp_strobe, rsp_data     shown for one cycle, cannot be held off
// config    csr_ APB port            written on psel, penable, pwrite
// Pushes are never refused while no page is pending.
// Closing a page runs the CRC over the whole page (header, lacing, payload);
// each byte is a store read then a fold, and busy stays high until it ends.
// A pull issues the registered store read, then shows the fetched byte.
// Reset is synchronous and clears the controller and all counters.
// The receiver cannot stall; every response appears once with rsp_strobe.
module ogg_page_framer import opf_pkg::*; #(
   parameter int MaxPacket = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [31:0] serial_ff;
   logic [15:0] step_ff;
   opf_cmd_type cmd;
   opf_stat_type stat;

   assign csr_pready = 1'b1;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff <= SerialReset;
         step_ff <= StepReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == RegSerial) begin
            serial_ff <= csr_pwdata;
         end else begin
            step_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[1:0] == 2'd0) begin
         csr_prdata = (csr_paddr[2] == RegStep) ? {16'd0, step_ff} : serial_ff;
      end
   end

   opf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   opf_datapath #(.MaxPacket(MaxPacket)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req(req_data),
      .serial(serial_ff), .step(step_ff), .rsp_data(rsp_data), .rsp_strobe(rsp_strobe)
   );
endmodule
`default_nettype wire
